// ===== sv/bsc_pkg.sv =====
package bsc_pkg;

    // Field and datapath widths.
    localparam int RAW_W        = 24;
    localparam int SCL_W        = 32;
    localparam int OUT_W        = 32;
    localparam int CODE_W       = 3;
    localparam int NUM_LANES    = 2;
    localparam int LANE_TEMP    = 0;
    localparam int LANE_PRES    = 1;

    // Pipeline depths.
    localparam int SCALE_STAGES = 4;
    localparam int POLY_STAGES  = 7;

    // Reciprocal divide: odd divisor m, reciprocal ceil(2^RECIP_SHIFT / m).
    localparam int M_W          = 8;
    localparam int RECIP_W      = 33;
    localparam int RECIP_SHIFT  = 32;
    localparam int SHIFT_W      = 4;
    localparam int BIAS_W       = 7;
    localparam int REM_W        = 19;

    // Polynomial datapath widths.
    localparam int Q_FRAC       = 24;
    localparam int D_W          = 48;
    localparam int TV_W         = 44;
    localparam int PH_W         = 56;
    localparam int PL_W         = 57;
    localparam int E_W          = 56;
    localparam int ACC_W        = 64;

    // Each scale factor is m * 2^s with m = 2^b - 1. Dividing the rounding
    // numerator by 2^(s+1) first leaves raw * 2^shift + (m-1)/2 over m.
    typedef struct packed {
        logic [M_W-1:0]     m;
        logic [RECIP_W-1:0] recip;
        logic [SHIFT_W-1:0] shift;
        logic [BIAS_W-1:0]  bias;
    } t_osr_entry;

    // Calibration coefficients, already unpacked from the registers.
    typedef struct packed {
        logic signed [11:0] c0;
        logic signed [11:0] c1;
        logic signed [19:0] c00;
        logic signed [19:0] c10;
        logic signed [15:0] c01;
        logic signed [15:0] c11;
        logic signed [15:0] c20;
        logic signed [15:0] c21;
        logic signed [15:0] c30;
    } t_poly_coefs;

    // Oversampling code to divisor entry.
    function automatic t_osr_entry osr_entry(input logic [CODE_W-1:0] code);
        t_osr_entry ent;
        case (code)
            3'd0: ent = '{m: 8'd1,   recip: 33'h1_0000_0000, shift: 4'd5,  bias: 7'd0};
            3'd1: ent = '{m: 8'd3,   recip: 33'd1431655766,  shift: 4'd5,  bias: 7'd1};
            3'd2: ent = '{m: 8'd7,   recip: 33'd613566757,   shift: 4'd5,  bias: 7'd3};
            3'd3: ent = '{m: 8'd15,  recip: 33'd286331154,   shift: 4'd5,  bias: 7'd7};
            3'd4: ent = '{m: 8'd31,  recip: 33'd138547333,   shift: 4'd11, bias: 7'd15};
            3'd5: ent = '{m: 8'd63,  recip: 33'd68174085,    shift: 4'd11, bias: 7'd31};
            3'd6: ent = '{m: 8'd127, recip: 33'd33818641,    shift: 4'd11, bias: 7'd63};
            3'd7: ent = '{m: 8'd255, recip: 33'd16843010,    shift: 4'd11, bias: 7'd127};
            default: ent = '{m: 8'd1, recip: 33'h1_0000_0000, shift: 4'd5, bias: 7'd0};
        endcase
        return ent;
    endfunction

endpackage

// ===== sv/barometric_sensor_compensation_top.sv =====
// An accepted input transaction passes through the reciprocal scaling stages
// and then the polynomial evaluation stages before its result reaches the output.
// Throughput: one transaction per cycle; every stage is a pipeline register
// with a valid bit, and a stalled output only holds the stages behind it.
// Reset (synchronous, active low) empties the pipeline and clears all
// coefficient and oversampling registers to zero.
module barometric_sensor_compensation_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_raw_temperature,
    input  logic signed [23:0] i_raw_pressure,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_temperature_q8,
    output logic signed [31:0] o_pressure_q4,
    output logic               o_saturated,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    import bsc_pkg::*;

    typedef enum logic [2:0] {
        REG_TEMP_COEFS   = 3'd0,
        REG_PRES_OFS_LIN = 3'd1,
        REG_PRES_CROSS   = 3'd2,
        REG_PRES_CUBIC   = 3'd3,
        REG_TEMP_OSR     = 3'd4,
        REG_PSR_OSR      = 3'd5
    } t_cfg_reg;

    logic [23:0]        r_temp_coefs;
    logic [39:0]        r_pres_ofs_lin;
    logic [63:0]        r_pres_cross;
    logic signed [15:0] r_pres_cubic;
    logic [CODE_W-1:0]  r_temp_osr;
    logic [CODE_W-1:0]  r_psr_osr;

    t_poly_coefs             coefs;
    logic signed [RAW_W-1:0] raw_lane  [NUM_LANES];
    logic [CODE_W-1:0]       code_lane [NUM_LANES];
    logic signed [SCL_W-1:0] scaled    [NUM_LANES];
    logic                    scl_valid;
    logic                    poly_stall;

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coefs   <= '0;
            r_pres_ofs_lin <= '0;
            r_pres_cross   <= '0;
            r_pres_cubic   <= '0;
            r_temp_osr     <= '0;
            r_psr_osr      <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_TEMP_COEFS:   r_temp_coefs   <= i_cfg_data[23:0];
                REG_PRES_OFS_LIN: r_pres_ofs_lin <= i_cfg_data[39:0];
                REG_PRES_CROSS:   r_pres_cross   <= i_cfg_data;
                REG_PRES_CUBIC:   r_pres_cubic   <= $signed(i_cfg_data[15:0]);
                REG_TEMP_OSR:     r_temp_osr     <= i_cfg_data[CODE_W-1:0];
                REG_PSR_OSR:      r_psr_osr      <= i_cfg_data[CODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Unpack the calibration coefficients.
    always_comb begin
        coefs.c0  = $signed(r_temp_coefs[23:12]);
        coefs.c1  = $signed(r_temp_coefs[11:0]);
        coefs.c00 = $signed(r_pres_ofs_lin[39:20]);
        coefs.c10 = $signed(r_pres_ofs_lin[19:0]);
        coefs.c01 = $signed(r_pres_cross[63:48]);
        coefs.c11 = $signed(r_pres_cross[47:32]);
        coefs.c20 = $signed(r_pres_cross[31:16]);
        coefs.c21 = $signed(r_pres_cross[15:0]);
        coefs.c30 = r_pres_cubic;
    end

    // Lane assignment for the scaling unit.
    always_comb begin
        raw_lane[LANE_TEMP]  = i_raw_temperature;
        raw_lane[LANE_PRES]  = i_raw_pressure;
        code_lane[LANE_TEMP] = r_temp_osr;
        code_lane[LANE_PRES] = r_psr_osr;
    end

    bsc_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_raw      (raw_lane),
        .i_osr_code (code_lane),
        .o_valid    (scl_valid),
        .i_stall    (poly_stall),
        .o_scaled   (scaled)
    );

    bsc_poly u_poly (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (scl_valid),
        .o_stall          (poly_stall),
        .i_t              (scaled[LANE_TEMP]),
        .i_p              (scaled[LANE_PRES]),
        .i_coefs          (coefs),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_temperature_q8 (o_temperature_q8),
        .o_pressure_q4    (o_pressure_q4),
        .o_saturated      (o_saturated)
    );

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && scl_valid && poly_stall))
        else $error("input stalled while the pipeline has room");

    a_sat_flag_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_pressure_q4 == 32'sh7fff_ffff) || (o_pressure_q4 == 32'sh8000_0000) ||
            (o_temperature_q8 == 32'sh7fff_ffff) || (o_temperature_q8 == 32'sh8000_0000))
        else $error("saturation flagged but no output sits at a bound");
`endif

endmodule

// ===== sv/bsc_scale.sv =====
module bsc_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [bsc_pkg::RAW_W-1:0]    i_raw [bsc_pkg::NUM_LANES],
    input  logic [bsc_pkg::CODE_W-1:0]          i_osr_code [bsc_pkg::NUM_LANES],
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [bsc_pkg::SCL_W-1:0]    o_scaled [bsc_pkg::NUM_LANES]
);
    import bsc_pkg::*;

    logic [SCALE_STAGES-1:0] r_vld;
    logic [SCALE_STAGES-1:0] n_vld;
    logic [SCALE_STAGES:0]   stg_go;

    t_osr_entry ent [NUM_LANES];

    // Stage registers, one set per lane.
    logic [RAW_W-1:0]        r_s0_mag [NUM_LANES];
    logic                    r_s0_neg [NUM_LANES];
    logic [RAW_W-1:0]        r_s1_q   [NUM_LANES];
    logic [RAW_W-1:0]        r_s1_mag [NUM_LANES];
    logic                    r_s1_neg [NUM_LANES];
    logic signed [RAW_W:0]   r_s2_qr  [NUM_LANES];
    logic [REM_W-1:0]        r_s2_v   [NUM_LANES];
    logic signed [SCL_W-1:0] r_s3_t   [NUM_LANES];

    // Combinational values between stages.
    logic [RAW_W-1:0]             n_mag  [NUM_LANES];
    logic [RAW_W+RECIP_W-1:0]     prod1  [NUM_LANES];
    logic [RAW_W+M_W-1:0]         qm     [NUM_LANES];
    logic [M_W-1:0]               rem    [NUM_LANES];
    logic signed [RAW_W:0]        qpos   [NUM_LANES];
    logic signed [RAW_W:0]        n_qr   [NUM_LANES];
    logic [M_W-1:0]               n_rr   [NUM_LANES];
    logic [REM_W-1:0]             n_v    [NUM_LANES];
    logic [REM_W+RECIP_W-1:0]     prod2  [NUM_LANES];
    logic signed [SCL_W-1:0]      n_t    [NUM_LANES];

    // Pipeline advance: a stage loads when it is empty or its successor moves.
    always_comb begin
        stg_go[SCALE_STAGES] = ~i_stall;
        for (int k = SCALE_STAGES - 1; k >= 0; k--) begin
            stg_go[k] = ~r_vld[k] | stg_go[k+1];
        end
        n_vld = {r_vld[SCALE_STAGES-2:0], i_valid};
    end

    assign o_stall = ~stg_go[0];
    assign o_valid = r_vld[SCALE_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < SCALE_STAGES; k++) begin
                if (stg_go[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Lane datapath: sign and magnitude, floor divide of the reading by m,
    // then a second divide of the remainder term scaled by the shift.
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            ent[l]   = osr_entry(i_osr_code[l]);
            n_mag[l] = i_raw[l][RAW_W-1] ? RAW_W'(-i_raw[l]) : RAW_W'(i_raw[l]);

            prod1[l] = (RAW_W+RECIP_W)'(r_s0_mag[l]) * (RAW_W+RECIP_W)'(ent[l].recip);

            qm[l]   = (RAW_W+M_W)'(r_s1_q[l]) * (RAW_W+M_W)'(ent[l].m);
            rem[l]  = M_W'((RAW_W+M_W)'(r_s1_mag[l]) - qm[l]);
            qpos[l] = $signed({1'b0, r_s1_q[l]});
            // A negative reading rounds its quotient toward minus infinity.
            if (r_s1_neg[l] && (rem[l] != '0)) begin
                n_qr[l] = ~qpos[l];
                n_rr[l] = ent[l].m - rem[l];
            end else if (r_s1_neg[l]) begin
                n_qr[l] = -qpos[l];
                n_rr[l] = rem[l];
            end else begin
                n_qr[l] = qpos[l];
                n_rr[l] = rem[l];
            end
            n_v[l] = (REM_W'(n_rr[l]) << ent[l].shift) + REM_W'(ent[l].bias);

            prod2[l] = (REM_W+RECIP_W)'(r_s2_v[l]) * (REM_W+RECIP_W)'(ent[l].recip);
            n_t[l]   = (SCL_W'(r_s2_qr[l]) <<< ent[l].shift)
                     + $signed(SCL_W'(prod2[l][RECIP_SHIFT +: REM_W]));
        end
    end

    // Stage 0: magnitude and sign of the raw reading.
    always_ff @(posedge i_clk) begin
        if (stg_go[0]) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_s0_mag[l] <= n_mag[l];
                r_s0_neg[l] <= i_raw[l][RAW_W-1];
            end
        end
    end

    // Stage 1: quotient of the magnitude by m.
    always_ff @(posedge i_clk) begin
        if (stg_go[1]) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_s1_q[l]   <= prod1[l][RECIP_SHIFT +: RAW_W];
                r_s1_mag[l] <= r_s0_mag[l];
                r_s1_neg[l] <= r_s0_neg[l];
            end
        end
    end

    // Stage 2: signed floor quotient and the remainder term.
    always_ff @(posedge i_clk) begin
        if (stg_go[2]) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_s2_qr[l] <= n_qr[l];
                r_s2_v[l]  <= n_v[l];
            end
        end
    end

    // Stage 3: scaled Q24 reading.
    always_ff @(posedge i_clk) begin
        if (stg_go[3]) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_s3_t[l] <= n_t[l];
            end
        end
    end

    assign o_scaled = r_s3_t;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (rem[0] < ent[0].m) && (rem[1] < ent[1].m))
        else $error("reciprocal quotient left a remainder not below the divisor");

    a_scaled_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_s3_t[0][SCL_W-1] == r_s3_t[0][SCL_W-2])
                  && (r_s3_t[1][SCL_W-1] == r_s3_t[1][SCL_W-2]))
        else $error("scaled reading exceeds its Q8.24 range");
`endif

endmodule

// ===== sv/bsc_poly.sv =====
module bsc_poly (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [bsc_pkg::SCL_W-1:0]  i_t,
    input  logic signed [bsc_pkg::SCL_W-1:0]  i_p,
    input  bsc_pkg::t_poly_coefs              i_coefs,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [bsc_pkg::OUT_W-1:0]  o_temperature_q8,
    output logic signed [bsc_pkg::OUT_W-1:0]  o_pressure_q4,
    output logic                              o_saturated
);
    import bsc_pkg::*;

    typedef struct packed {
        logic                    sat;
        logic signed [OUT_W-1:0] val;
    } t_clip;

    // Clip a wide signed value to the 32-bit output range.
    function automatic t_clip clip_out(input logic signed [ACC_W-1:0] v);
        t_clip res;
        if (v > 64'sd2147483647) begin
            res = '{sat: 1'b1, val: 32'sh7fff_ffff};
        end else if (v < -64'sd2147483648) begin
            res = '{sat: 1'b1, val: 32'sh8000_0000};
        end else begin
            res = '{sat: 1'b0, val: v[OUT_W-1:0]};
        end
        return res;
    endfunction

    logic [POLY_STAGES-1:0] r_vld;
    logic [POLY_STAGES-1:0] n_vld;
    logic [POLY_STAGES:0]   stg_go;

    // Stage registers.
    logic signed [SCL_W-1:0] r_s0_t, r_s0_p;
    logic signed [D_W-1:0]   r_s0_d, r_s0_g, r_s0_ct;
    logic signed [TV_W-1:0]  r_s0_tv;

    logic signed [SCL_W-1:0] r_s1_t, r_s1_p;
    logic signed [D_W-1:0]   r_s1_ct;
    logic signed [PH_W-1:0]  r_s1_pd_hi, r_s1_pg_hi;
    logic signed [PL_W-1:0]  r_s1_pd_lo, r_s1_pg_lo;
    logic signed [OUT_W-1:0] r_s1_temp;
    logic                    r_s1_tsat;

    logic signed [SCL_W-1:0] r_s2_t, r_s2_p;
    logic signed [D_W-1:0]   r_s2_ct;
    logic signed [E_W-1:0]   r_s2_e, r_s2_mg;
    logic signed [OUT_W-1:0] r_s2_temp;
    logic                    r_s2_tsat;

    logic signed [ACC_W-1:0] r_s3_pe_hi, r_s3_tm_hi, r_s3_cs;
    logic signed [PL_W-1:0]  r_s3_pe_lo, r_s3_tm_lo;
    logic signed [OUT_W-1:0] r_s3_temp;
    logic                    r_s3_tsat;

    logic signed [ACC_W-1:0] r_s4_f, r_s4_h, r_s4_cs;
    logic signed [OUT_W-1:0] r_s4_temp;
    logic                    r_s4_tsat;

    logic signed [ACC_W-1:0] r_s5_acc;
    logic signed [OUT_W-1:0] r_s5_temp;
    logic                    r_s5_tsat;

    logic signed [OUT_W-1:0] r_s6_temp, r_s6_pres;
    logic                    r_s6_sat;

    // Combinational values between stages.
    logic signed [D_W-1:0]   n_d, n_g, n_ct;
    logic signed [TV_W-1:0]  n_tv, tv_rnd;
    t_clip                   temp_clip, pres_clip;
    logic signed [E_W-1:0]   n_e, n_mg;
    logic signed [ACC_W-1:0] n_f, n_h, n_cs, n_acc, acc_rnd;

    // Pipeline advance.
    always_comb begin
        stg_go[POLY_STAGES] = ~i_stall;
        for (int k = POLY_STAGES - 1; k >= 0; k--) begin
            stg_go[k] = ~r_vld[k] | stg_go[k+1];
        end
        n_vld = {r_vld[POLY_STAGES-2:0], i_valid};
    end

    assign o_stall = ~stg_go[0];
    assign o_valid = r_vld[POLY_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < POLY_STAGES; k++) begin
                if (stg_go[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Linear terms: d, g, temperature value and the c01 product.
    always_comb begin
        n_d  = (D_W'($signed(i_coefs.c20)) <<< Q_FRAC)
             + D_W'($signed(i_coefs.c30)) * D_W'(i_p);
        n_g  = (D_W'($signed(i_coefs.c11)) <<< Q_FRAC)
             + D_W'($signed(i_coefs.c21)) * D_W'(i_p);
        n_tv = (TV_W'($signed(i_coefs.c0)) <<< (Q_FRAC - 1))
             + TV_W'($signed(i_coefs.c1)) * TV_W'(i_t);
        n_ct = D_W'($signed(i_coefs.c01)) * D_W'(i_t);
    end

    always_ff @(posedge i_clk) begin
        if (stg_go[0]) begin
            r_s0_t  <= i_t;
            r_s0_p  <= i_p;
            r_s0_d  <= n_d;
            r_s0_g  <= n_g;
            r_s0_tv <= n_tv;
            r_s0_ct <= n_ct;
        end
    end

    // Partial products of p with the upper and lower halves of d and g;
    // temperature rounding and clipping.
    always_comb begin
        tv_rnd    = r_s0_tv + TV_W'(32768);
        temp_clip = clip_out(ACC_W'(tv_rnd >>> 16));
    end

    always_ff @(posedge i_clk) begin
        if (stg_go[1]) begin
            r_s1_t     <= r_s0_t;
            r_s1_p     <= r_s0_p;
            r_s1_ct    <= r_s0_ct;
            r_s1_pd_hi <= PH_W'(r_s0_p) * PH_W'($signed(r_s0_d[D_W-1:Q_FRAC]));
            r_s1_pd_lo <= PL_W'(r_s0_p) * PL_W'($signed({1'b0, r_s0_d[Q_FRAC-1:0]}));
            r_s1_pg_hi <= PH_W'(r_s0_p) * PH_W'($signed(r_s0_g[D_W-1:Q_FRAC]));
            r_s1_pg_lo <= PL_W'(r_s0_p) * PL_W'($signed({1'b0, r_s0_g[Q_FRAC-1:0]}));
            r_s1_temp  <= temp_clip.val;
            r_s1_tsat  <= temp_clip.sat;
        end
    end

    // Combine partial products: e = c10 + p*d, and p*g.
    always_comb begin
        n_e  = (E_W'($signed(i_coefs.c10)) <<< Q_FRAC)
             + E_W'(r_s1_pd_hi) + E_W'(r_s1_pd_lo >>> Q_FRAC);
        n_mg = E_W'(r_s1_pg_hi) + E_W'(r_s1_pg_lo >>> Q_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (stg_go[2]) begin
            r_s2_t    <= r_s1_t;
            r_s2_p    <= r_s1_p;
            r_s2_ct   <= r_s1_ct;
            r_s2_e    <= n_e;
            r_s2_mg   <= n_mg;
            r_s2_temp <= r_s1_temp;
            r_s2_tsat <= r_s1_tsat;
        end
    end

    // Partial products of p*e and t*(p*g); constant and c01 terms summed.
    always_comb begin
        n_cs = (ACC_W'($signed(i_coefs.c00)) <<< Q_FRAC) + ACC_W'(r_s2_ct);
    end

    always_ff @(posedge i_clk) begin
        if (stg_go[3]) begin
            r_s3_pe_hi <= ACC_W'(r_s2_p) * ACC_W'($signed(r_s2_e[E_W-1:Q_FRAC]));
            r_s3_pe_lo <= PL_W'(r_s2_p) * PL_W'($signed({1'b0, r_s2_e[Q_FRAC-1:0]}));
            r_s3_tm_hi <= ACC_W'(r_s2_t) * ACC_W'($signed(r_s2_mg[E_W-1:Q_FRAC]));
            r_s3_tm_lo <= PL_W'(r_s2_t) * PL_W'($signed({1'b0, r_s2_mg[Q_FRAC-1:0]}));
            r_s3_cs    <= n_cs;
            r_s3_temp  <= r_s2_temp;
            r_s3_tsat  <= r_s2_tsat;
        end
    end

    // f = p*e and h = t*p*g, each floored to Q24.
    always_comb begin
        n_f = r_s3_pe_hi + ACC_W'(r_s3_pe_lo >>> Q_FRAC);
        n_h = r_s3_tm_hi + ACC_W'(r_s3_tm_lo >>> Q_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (stg_go[4]) begin
            r_s4_f    <= n_f;
            r_s4_h    <= n_h;
            r_s4_cs   <= r_s3_cs;
            r_s4_temp <= r_s3_temp;
            r_s4_tsat <= r_s3_tsat;
        end
    end

    // Pressure accumulator.
    always_comb begin
        n_acc = r_s4_f + r_s4_h + r_s4_cs;
    end

    always_ff @(posedge i_clk) begin
        if (stg_go[5]) begin
            r_s5_acc  <= n_acc;
            r_s5_temp <= r_s4_temp;
            r_s5_tsat <= r_s4_tsat;
        end
    end

    // Output register: pressure rounded to 1/16 Pa and clipped.
    always_comb begin
        acc_rnd   = r_s5_acc + ACC_W'(524288);
        pres_clip = clip_out(acc_rnd >>> 20);
    end

    always_ff @(posedge i_clk) begin
        if (stg_go[6]) begin
            r_s6_temp <= r_s5_temp;
            r_s6_pres <= pres_clip.val;
            r_s6_sat  <= r_s5_tsat | pres_clip.sat;
        end
    end

    assign o_temperature_q8 = r_s6_temp;
    assign o_pressure_q4    = r_s6_pres;
    assign o_saturated      = r_s6_sat;

`ifndef SYNTH
    a_temp_never_clips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> !r_s1_tsat)
        else $error("temperature path clipped although its range cannot overflow");
`endif

endmodule

// ===== tb/sv/barometric_sensor_compensation_top_test.sv =====
module barometric_sensor_compensation_top_test;
    import bsc_pkg::*;

    // Wide signed type for exact polynomial arithmetic.
    typedef logic signed [127:0] wide_t;

    // Register map of the configuration port.
    typedef enum logic [2:0] {
        REG_TEMP_COEFS         = 3'd0,
        REG_PRES_OFFSET_LINEAR = 3'd1,
        REG_PRES_CROSS         = 3'd2,
        REG_PRES_CUBIC         = 3'd3,
        REG_TEMP_OSR           = 3'd4,
        REG_PSR_OSR            = 3'd5,
        REG_SPARE6             = 3'd6,
        REG_SPARE7             = 3'd7
    } cfg_reg_e;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // One compensated reading as it leaves the block.
    typedef struct packed {
        logic signed [OUT_W-1:0] temperature_q8;
        logic signed [OUT_W-1:0] pressure_q4;
        logic                    saturated;
    } reading_t;

    // One row of the directed table: a register write or a sample pair.
    typedef struct packed {
        row_kind_e               kind;
        cfg_reg_e                reg_idx;
        logic [63:0]             cfg_data;
        logic signed [RAW_W-1:0] raw_t;
        logic signed [RAW_W-1:0] raw_p;
        logic                    typed;
        logic signed [OUT_W-1:0] exp_t;
        logic signed [OUT_W-1:0] exp_p;
        logic                    exp_sat;
    } dir_row_t;

    localparam int LATENCY         = 11;
    localparam int DRAIN_CYCLES    = 3 * LATENCY;
    localparam int HOLD_CYCLES     = 200;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int HOLD_PHASE      = 3;
    localparam int TIMEOUT_UNITS   = 2000000;

    localparam int STYLE_MIX = 0;
    localparam int STYLE_MAX = 1;
    localparam int STYLE_MIN = 2;

    localparam logic signed [RAW_W-1:0] RAW_MAX = 24'sh7FFFFF;
    localparam logic signed [RAW_W-1:0] RAW_MIN = 24'sh800000;
    localparam logic signed [OUT_W-1:0] Q_MAX   = 32'sh7FFFFFFF;
    localparam logic signed [OUT_W-1:0] Q_MIN   = 32'sh80000000;

    localparam wide_t HALF_T = 128'sd32768;
    localparam wide_t HALF_P = 128'sd524288;
    localparam wide_t MAX32  = 128'sd2147483647;
    localparam wide_t MIN32  = -128'sd2147483648;

    localparam int DIR_ROWS = 40;

    // Directed stimulus. Rows with a typed result compare against it directly.
    dir_row_t dir_table [DIR_ROWS] = '{
        // Everything zero after reset.
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MAX, RAW_MIN, 1'b1, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MIN, RAW_MAX, 1'b1, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, 24'sd0, 24'sd0, 1'b1, 32'sd0, 32'sd0, 1'b0},
        // Unit slope, largest offset, unity scale: temperature follows the reading, pressure holds the offset.
        '{ROW_CFG, REG_TEMP_COEFS, 64'h1, 24'sd0, 24'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_PRES_OFFSET_LINEAR, 64'h0000_007F_FFF0_0000, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MAX, 24'sd0, 1'b1, 32'sd4096, 32'sd8388592, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MIN, 24'sd123, 1'b1, -32'sd4096, 32'sd8388592,
          1'b0},
        // Exact halves round toward plus infinity.
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, 24'sd1024, 24'sd0, 1'b1, 32'sd1, 32'sd8388592, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, -24'sd1024, 24'sd0, 1'b1, 32'sd0, 32'sd8388592, 1'b0},
        // Most negative offset, with junk above the register width.
        '{ROW_CFG, REG_PRES_OFFSET_LINEAR, 64'hABCD_EF80_0000_0000, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, 24'sd0, 24'sd0, 1'b1, 32'sd0, -32'sd8388608, 1'b0},
        // Largest offset with most negative slope.
        '{ROW_CFG, REG_TEMP_COEFS, 64'hFFFF_FFFF_FF7F_F800, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MAX, RAW_MAX, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MIN, RAW_MIN, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, 24'sd1, -24'sd1, 1'b0, 32'sd0, 32'sd0, 1'b0},
        // All pressure coefficients at their maximum, largest oversampling.
        '{ROW_CFG, REG_PRES_OFFSET_LINEAR, 64'h0000_007F_FFF7_FFFF, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_PRES_CROSS, 64'h7FFF_7FFF_7FFF_7FFF, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_PRES_CUBIC, 64'h7FFF, 24'sd0, 24'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_TEMP_OSR, 64'h7, 24'sd0, 24'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_PSR_OSR, 64'h7, 24'sd0, 24'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MAX, RAW_MAX, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MIN, RAW_MAX, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MAX, RAW_MIN, 1'b0, 32'sd0, 32'sd0, 1'b0},
        // All pressure coefficients at their minimum, smallest scale factor.
        '{ROW_CFG, REG_PRES_OFFSET_LINEAR, 64'h0000_0080_0008_0000, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_PRES_CROSS, 64'h8000_8000_8000_8000, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_PRES_CUBIC, 64'hFFFF_FFFF_FFFF_8000, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_TEMP_OSR, 64'hFFFF_FFFF_FFFF_FFFC, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_PSR_OSR, 64'h4, 24'sd0, 24'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MAX, RAW_MAX, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MIN, RAW_MIN, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, RAW_MIN, RAW_MAX, 1'b0, 32'sd0, 32'sd0, 1'b0},
        // Writes to the unused indexes must leave every register alone.
        '{ROW_CFG, REG_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_SPARE7, 64'hFFFF_FFFF_FFFF_FFFF, 24'sd0, 24'sd0, 1'b0,
          32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, 24'sd1000, -24'sd1000, 1'b0, 32'sd0, 32'sd0, 1'b0},
        // A lone cubic term drives the pressure into both saturation bounds.
        '{ROW_CFG, REG_TEMP_COEFS, 64'h0, 24'sd0, 24'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_PRES_OFFSET_LINEAR, 64'h0, 24'sd0, 24'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_PRES_CROSS, 64'h0, 24'sd0, 24'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_CFG, REG_PRES_CUBIC, 64'h7FFF, 24'sd0, 24'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, 24'sd0, RAW_MAX, 1'b1, 32'sd0, Q_MAX, 1'b1},
        '{ROW_ITEM, REG_TEMP_COEFS, 64'h0, 24'sd0, RAW_MIN, 1'b1, 32'sd0, Q_MIN, 1'b1}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [RAW_W-1:0] i_raw_temperature;
    logic signed [RAW_W-1:0] i_raw_pressure;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [OUT_W-1:0] o_temperature_q8;
    logic signed [OUT_W-1:0] o_pressure_q4;
    logic                    o_saturated;
    logic                    i_cfg_wr_en;
    logic [2:0]              i_cfg_index;
    logic [63:0]             i_cfg_data;

    // Shadow copies of the calibration registers.
    logic [23:0]       temp_coefs_r;
    logic [39:0]       pres_offset_linear_r;
    logic [63:0]       pres_cross_r;
    logic [15:0]       pres_cubic_r;
    logic [CODE_W-1:0] temp_osr_r;
    logic [CODE_W-1:0] psr_osr_r;

    reading_t pending_readings [$];
    int       mismatches = 0;
    logic     tx_quiet   = 1'b0;
    logic     rx_quiet   = 1'b0;
    logic     hold_req   = 1'b0;

    barometric_sensor_compensation_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_temperature_q8  (o_temperature_q8),
        .o_pressure_q4     (o_pressure_q4),
        .o_saturated       (o_saturated),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Divide a raw reading by its oversampling scale factor into Q24,
    // rounding to nearest with halves going up.
    function automatic wide_t scale_reading(input logic signed [RAW_W-1:0] raw,
                                            input logic [CODE_W-1:0] code);
        wide_t k;
        wide_t num;
        wide_t den;
        wide_t q;
        case (code)
            3'd0:    k = 128'sd524288;
            3'd1:    k = 128'sd1572864;
            3'd2:    k = 128'sd3670016;
            3'd3:    k = 128'sd7864320;
            3'd4:    k = 128'sd253952;
            3'd5:    k = 128'sd516096;
            3'd6:    k = 128'sd1040384;
            default: k = 128'sd2088960;
        endcase
        num = raw;
        num = (num <<< 25) + k;
        den = k <<< 1;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Compensated temperature and pressure for one sample pair under the
    // current register settings.
    function automatic reading_t compensate(input logic signed [RAW_W-1:0] raw_t,
                                            input logic signed [RAW_W-1:0] raw_p);
        wide_t    t, p;
        wide_t    c0, c1, c00, c10, c01, c11, c20, c21, c30;
        wide_t    tv, d, e, f, g, h, acc, tq, pq;
        reading_t r;
        t   = scale_reading(raw_t, temp_osr_r);
        p   = scale_reading(raw_p, psr_osr_r);
        c0  = $signed(temp_coefs_r[23:12]);
        c1  = $signed(temp_coefs_r[11:0]);
        c00 = $signed(pres_offset_linear_r[39:20]);
        c10 = $signed(pres_offset_linear_r[19:0]);
        c01 = $signed(pres_cross_r[63:48]);
        c11 = $signed(pres_cross_r[47:32]);
        c20 = $signed(pres_cross_r[31:16]);
        c21 = $signed(pres_cross_r[15:0]);
        c30 = $signed(pres_cubic_r);

        // Temperature: offset is halved, so it enters at 2^23.
        tv = (c0 <<< 23) + c1 * t;
        tq = (tv + HALF_T) >>> 16;

        // Pressure in Horner form; every product of two Q24 values is floored back to Q24.
        d   = (c20 <<< 24) + c30 * p;
        e   = (c10 <<< 24) + ((p * d) >>> 24);
        f   = (p * e) >>> 24;
        g   = (c11 <<< 24) + c21 * p;
        h   = (t * ((p * g) >>> 24)) >>> 24;
        acc = (c00 <<< 24) + f + c01 * t + h;
        pq  = (acc + HALF_P) >>> 20;

        r.saturated = 1'b0;
        if (tq > MAX32) begin
            r.temperature_q8 = Q_MAX;
            r.saturated = 1'b1;
        end else if (tq < MIN32) begin
            r.temperature_q8 = Q_MIN;
            r.saturated = 1'b1;
        end else begin
            r.temperature_q8 = tq[OUT_W-1:0];
        end
        if (pq > MAX32) begin
            r.pressure_q4 = Q_MAX;
            r.saturated = 1'b1;
        end else if (pq < MIN32) begin
            r.pressure_q4 = Q_MIN;
            r.saturated = 1'b1;
        end else begin
            r.pressure_q4 = pq[OUT_W-1:0];
        end
        return r;
    endfunction

    // Signed coefficient bit pattern of the given width.
    function automatic logic [63:0] draw_coef(input int w, input int style);
        logic [63:0] mask;
        logic [63:0] v;
        mask = (64'd1 << w) - 64'd1;
        if (style == STYLE_MAX) begin
            v = mask >> 1;
        end else if (style == STYLE_MIN) begin
            v = 64'd1 << (w - 1);
        end else begin
            case ($urandom_range(0, 7))
                0:       v = mask >> 1;
                1:       v = 64'd1 << (w - 1);
                2:       v = {32'd0, $urandom_range(0, 16) - 32'd8};
                default: v = {$urandom(), $urandom()};
            endcase
        end
        return v & mask;
    endfunction

    // Fill the bits above a register's width with noise.
    function automatic logic [63:0] pad_above(input logic [63:0] val, input int w);
        logic [63:0] noise;
        noise = {$urandom(), $urandom()};
        return val | (noise << w);
    endfunction

    function automatic logic signed [RAW_W-1:0] draw_raw();
        logic [31:0] bits;
        bits = $urandom();
        case ($urandom_range(0, 7))
            0:       return RAW_MAX;
            1:       return RAW_MIN;
            2:       return RAW_W'($signed({1'b0, bits[5:0]}) - 32);
            default: return bits[RAW_W-1:0];
        endcase
    endfunction

    // Register write through the configuration port, mirrored in the shadow copy.
    task automatic write_reg(input cfg_reg_e idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            REG_TEMP_COEFS:         temp_coefs_r         = data[23:0];
            REG_PRES_OFFSET_LINEAR: pres_offset_linear_r = data[39:0];
            REG_PRES_CROSS:         pres_cross_r         = data;
            REG_PRES_CUBIC:         pres_cubic_r         = data[15:0];
            REG_TEMP_OSR:           temp_osr_r           = data[CODE_W-1:0];
            REG_PSR_OSR:            psr_osr_r            = data[CODE_W-1:0];
            default:                ;
        endcase
    endtask

    // Drop valid and wait until every outstanding reading has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Offer one sample pair and record its expected reading once accepted.
    task automatic send_reading(input logic signed [RAW_W-1:0] raw_t,
                                input logic signed [RAW_W-1:0] raw_p,
                                input logic typed, input reading_t typed_res);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid           = 1'b1;
        i_raw_temperature = raw_t;
        i_raw_pressure    = raw_p;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_readings.push_back(typed ? typed_res : compensate(raw_t, raw_p));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run.
    initial begin
        #(TIMEOUT_UNITS);
        $display("barometric_sensor_compensation_top verification failed");
        $finish;
    end

    // Result side: random stall before each transaction, then check it.
    initial begin
        int       hold;
        reading_t want;
        i_stall = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            hold = rx_quiet ? 0 : $urandom_range(0, 19);
            if (hold_req) begin
                hold = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            @(negedge i_clk);
            if (hold > 0) begin
                i_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);

            if (pending_readings.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result: temp=%0d pres=%0d sat=%0b",
                             o_temperature_q8, o_pressure_q4, o_saturated);
                end
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                if (o_temperature_q8 !== want.temperature_q8 ||
                    o_pressure_q4 !== want.pressure_q4 ||
                    o_saturated !== want.saturated) begin
                    if (mismatches < 10) begin
                        $display("mismatch: temp exp %0d got %0d, pres exp %0d got %0d, sat exp %0b got %0b",
                                 want.temperature_q8, o_temperature_q8,
                                 want.pressure_q4, o_pressure_q4,
                                 want.saturated, o_saturated);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then randomized configuration phases.
    initial begin
        reading_t row_res;
        int       style;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure    = '0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = REG_TEMP_COEFS;
        i_cfg_data        = '0;
        temp_coefs_r         = '0;
        pres_offset_linear_r = '0;
        pres_cross_r         = '0;
        pres_cubic_r         = '0;
        temp_osr_r           = '0;
        psr_osr_r            = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_table[i].reg_idx, dir_table[i].cfg_data);
            end else begin
                row_res.temperature_q8 = dir_table[i].exp_t;
                row_res.pressure_q4    = dir_table[i].exp_p;
                row_res.saturated      = dir_table[i].exp_sat;
                send_reading(dir_table[i].raw_t, dir_table[i].raw_p,
                             dir_table[i].typed, row_res);
            end
        end

        // The first two phases pin every coefficient to an extreme.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            style = (phase == 0) ? STYLE_MAX : (phase == 1) ? STYLE_MIN : STYLE_MIX;
            write_reg(REG_TEMP_COEFS,
                      pad_above((draw_coef(12, style) << 12) | draw_coef(12, style), 24));
            write_reg(REG_PRES_OFFSET_LINEAR,
                      pad_above((draw_coef(20, style) << 20) | draw_coef(20, style), 40));
            write_reg(REG_PRES_CROSS,
                      (draw_coef(16, style) << 48) | (draw_coef(16, style) << 32) |
                      (draw_coef(16, style) << 16) | draw_coef(16, style));
            write_reg(REG_PRES_CUBIC, pad_above(draw_coef(16, style), 16));
            if (style == STYLE_MAX) begin
                write_reg(REG_TEMP_OSR, pad_above(64'd7, CODE_W));
                write_reg(REG_PSR_OSR, pad_above(64'd7, CODE_W));
            end else if (style == STYLE_MIN) begin
                write_reg(REG_TEMP_OSR, pad_above(64'd0, CODE_W));
                write_reg(REG_PSR_OSR, pad_above(64'd0, CODE_W));
            end else begin
                write_reg(REG_TEMP_OSR, pad_above({61'd0, CODE_W'($urandom_range(0, 7))}, CODE_W));
                write_reg(REG_PSR_OSR, pad_above({61'd0, CODE_W'($urandom_range(0, 7))}, CODE_W));
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE7 : REG_SPARE6,
                          {$urandom(), $urandom()});
            end

            // Some phases run back to back on one side; one holds the output
            // off for a long stretch so the pipeline fills and stalls its input.
            tx_quiet = (phase % 4 == 2) || (phase == HOLD_PHASE);
            rx_quiet = (phase % 4 == 1);
            if (phase == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                send_reading(draw_raw(), draw_raw(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("barometric_sensor_compensation_top verification clean");
        end else begin
            $display("barometric_sensor_compensation_top verification failed");
        end
        $finish;
    end

endmodule
